>>> design/esps_pkg.sv
// Shared types and constants of the exact stamp pair synchronizer.
// Holds the item mode codes, the register indexes, the queue entry and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package esps_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  // Item modes carried in in_tuser
  typedef enum logic [1:0] {
    MODE_IMAGE = 2'd0,
    MODE_INFO  = 2'd1,
    MODE_DEPTH = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Result kinds carried in out_tuser
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_DEPTH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_EN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_EN   = 4'd3;

  // Register reset values
  localparam logic [15:0] RST_EXP_WIDTH  = 16'd640;
  localparam logic [15:0] RST_EXP_HEIGHT = 16'd480;

  typedef struct packed {
    logic signed [31:0] sec;
    logic [29:0]        nsec;
  } stamp_t;

  typedef struct packed {
    logic [15:0] tag;
    stamp_t      stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the input transfer
    logic clear;      // empty both queues
    logic evict;      // drop oldest entry of own queue if full
    logic scan_init;  // rewind the scan pointer
    logic scan;       // scan the other queue for an equal stamp
    logic shift;      // close the gap left by the matched entry
    logic remove;     // shrink the other queue by one
    logic append;     // write the item into its own queue
    logic load_out;   // load the output register
    logic out_kind;   // kind of the loaded result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  size_ok;
    logic  depth_en;
    logic  pair_en;
    logic  other_empty;
    logic  hit;
    logic  scan_miss;
    logic  shift_done;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

>>> design/esps_ctrl.sv
// Controller of the exact stamp pair synchronizer: sequences one item
// through check, scan, gap closing, append and result load.
// Depends on esps_pkg for the command and status structs.
`default_nettype none

module esps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire esps_pkg::status_t st,
  output esps_pkg::cmd_t        cmd
);
  import esps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_APPEND,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   kind_r, kind_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.out_kind = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.mode == MODE_CLEAR) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (!st.size_ok) begin
          state_nxt = S_IDLE;
        end else if (st.mode == MODE_DEPTH) begin
          if (st.depth_en) begin
            kind_nxt  = KIND_DEPTH;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.evict     = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt     = st.other_empty ? S_APPEND : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          state_nxt = S_SHIFT;
        end else if (st.scan_miss) begin
          state_nxt = S_APPEND;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) begin
          cmd.remove = 1'b1;
          if (st.pair_en) begin
            kind_nxt  = KIND_PAIR;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_PAIR;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/esps_datapath.sv
// Datapath of the exact stamp pair synchronizer: configuration registers,
// item register, two circular stamp queues in memory and the output register.
// Depends on esps_pkg; driven by esps_ctrl through cmd_t, reports status_t.
`default_nettype none

module esps_datapath #(
  parameter int QUEUE_DEPTH = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire esps_pkg::cmd_t                       cmd,
  output esps_pkg::status_t                         st,
  input  wire logic [esps_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic [esps_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [esps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [esps_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [esps_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic [0:0]                                out_tuser
);
  import esps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // Physical slot of queue position off behind head
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Configuration
  logic [15:0] exp_w_r, exp_h_r;
  logic        pair_en_r, depth_en_r;

  // Current item
  mode_t       mode_r;
  stamp_t      stamp_r;
  logic [15:0] tag_r, fw_r, fh_r;

  // Queue bookkeeping
  logic [PTR_W-1:0] img_head_r, img_head_nxt, inf_head_r, inf_head_nxt;
  logic [CNT_W-1:0] img_cnt_r, img_cnt_nxt, inf_cnt_r, inf_cnt_nxt;

  // Scan and gap-closing pointers
  logic [CNT_W-1:0] idx_r, idx_nxt, rv_idx_r, rv_idx_nxt;
  logic             rv_r, rv_nxt;
  logic [15:0]      hit_tag_r, hit_tag_nxt;

  // Memories
  entry_t           img_mem [QUEUE_DEPTH];
  entry_t           inf_mem [QUEUE_DEPTH];
  entry_t           img_rd_r, inf_rd_r;
  logic             img_we, inf_we;
  logic [PTR_W-1:0] img_waddr, inf_waddr, img_raddr, inf_raddr;
  entry_t           img_wdata, inf_wdata, new_entry, other_rd;

  // Output register
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic             own_img, match, issue, sh_we;
  logic [CNT_W-1:0] other_cnt, sh_off;

  assign own_img   = (mode_r == MODE_IMAGE);
  assign other_cnt = own_img ? inf_cnt_r : img_cnt_r;
  assign other_rd  = own_img ? inf_rd_r : img_rd_r;
  assign match     = (other_rd.stamp == stamp_r);
  assign new_entry = '{tag: tag_r, stamp: stamp_r};

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_w_r    <= RST_EXP_WIDTH;
      exp_h_r    <= RST_EXP_HEIGHT;
      pair_en_r  <= 1'b0;
      depth_en_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXP_WIDTH:  exp_w_r    <= cfg_data;
        CFG_EXP_HEIGHT: exp_h_r    <= cfg_data;
        CFG_PAIR_EN:    pair_en_r  <= cfg_data[0];
        CFG_DEPTH_EN:   depth_en_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CLEAR;
    end else if (cmd.latch) begin
      mode_r <= mode_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      stamp_r.sec  <= in_tdata[31:0];
      stamp_r.nsec <= in_tdata[61:32];
      fw_r         <= in_tdata[77:62];
      fh_r         <= in_tdata[93:78];
      tag_r        <= in_tdata[109:94];
    end
  end

  // Scan pointer: issue one read a cycle, compare the registered data
  assign issue = (cmd.scan || cmd.shift) && (idx_r < other_cnt);

  always_comb begin
    idx_nxt     = idx_r;
    rv_nxt      = 1'b0;
    rv_idx_nxt  = rv_idx_r;
    hit_tag_nxt = hit_tag_r;
    if (issue) begin
      idx_nxt    = idx_r + CNT_W'(1);
      rv_nxt     = 1'b1;
      rv_idx_nxt = idx_r;
    end
    // On a hit, restart the pointer just past the matched entry
    if (cmd.scan && rv_r && match) begin
      idx_nxt     = rv_idx_r + CNT_W'(1);
      rv_nxt      = 1'b0;
      hit_tag_nxt = other_rd.tag;
    end
    if (cmd.scan_init) begin
      idx_nxt = '0;
      rv_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rv_r     <= 1'b0;
      rv_idx_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      rv_r     <= rv_nxt;
      rv_idx_r <= rv_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_tag_r <= hit_tag_nxt;
  end

  // Memory ports: append into own queue, gap closing in the other queue
  assign sh_we  = cmd.shift && rv_r;
  assign sh_off = rv_idx_r - CNT_W'(1);

  assign img_raddr = wrap_add(img_head_r, idx_r);
  assign inf_raddr = wrap_add(inf_head_r, idx_r);
  assign img_we    = own_img ? cmd.append : sh_we;
  assign inf_we    = own_img ? sh_we : cmd.append;
  assign img_waddr = wrap_add(img_head_r, own_img ? img_cnt_r : sh_off);
  assign inf_waddr = wrap_add(inf_head_r, own_img ? sh_off : inf_cnt_r);
  assign img_wdata = own_img ? new_entry : img_rd_r;
  assign inf_wdata = own_img ? inf_rd_r : new_entry;

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    img_rd_r <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (inf_we) begin
      inf_mem[inf_waddr] <= inf_wdata;
    end
    inf_rd_r <= inf_mem[inf_raddr];
  end

  // Queue heads and counts
  always_comb begin
    img_head_nxt = img_head_r;
    img_cnt_nxt  = img_cnt_r;
    inf_head_nxt = inf_head_r;
    inf_cnt_nxt  = inf_cnt_r;
    if (cmd.clear) begin
      img_cnt_nxt = '0;
      inf_cnt_nxt = '0;
    end
    // Evict the oldest entry of a full queue
    if (cmd.evict && own_img && (img_cnt_r == DEPTH_C)) begin
      img_head_nxt = wrap_add(img_head_r, CNT_W'(1));
      img_cnt_nxt  = img_cnt_r - CNT_W'(1);
    end
    if (cmd.evict && !own_img && (inf_cnt_r == DEPTH_C)) begin
      inf_head_nxt = wrap_add(inf_head_r, CNT_W'(1));
      inf_cnt_nxt  = inf_cnt_r - CNT_W'(1);
    end
    if (cmd.remove) begin
      if (own_img) begin
        inf_cnt_nxt = inf_cnt_r - CNT_W'(1);
      end else begin
        img_cnt_nxt = img_cnt_r - CNT_W'(1);
      end
    end
    if (cmd.append) begin
      if (own_img) begin
        img_cnt_nxt = img_cnt_r + CNT_W'(1);
      end else begin
        inf_cnt_nxt = inf_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_head_r <= '0;
      img_cnt_r  <= '0;
      inf_head_r <= '0;
      inf_cnt_r  <= '0;
    end else begin
      img_head_r <= img_head_nxt;
      img_cnt_r  <= img_cnt_nxt;
      inf_head_r <= inf_head_nxt;
      inf_cnt_r  <= inf_cnt_nxt;
    end
  end

  // Output register: valid flag under reset, payload loaded on command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r        <= cmd.out_kind;
      out_data_r[95:94] <= 2'b00;
      out_data_r[63:32] <= stamp_r.sec;
      out_data_r[93:64] <= stamp_r.nsec;
      if (cmd.out_kind == KIND_DEPTH) begin
        out_data_r[15:0]  <= tag_r;
        out_data_r[31:16] <= 16'd0;
      end else if (own_img) begin
        out_data_r[15:0]  <= tag_r;
        out_data_r[31:16] <= hit_tag_r;
      end else begin
        out_data_r[15:0]  <= hit_tag_r;
        out_data_r[31:16] <= tag_r;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

  // Status to the controller
  always_comb begin
    st             = '0;
    st.mode        = mode_r;
    st.size_ok     = (fw_r == exp_w_r) && (fh_r == exp_h_r);
    st.depth_en    = depth_en_r;
    st.pair_en     = pair_en_r;
    st.other_empty = (other_cnt == '0);
    st.hit         = rv_r && match;
    st.scan_miss   = rv_r && !match && ((rv_idx_r + CNT_W'(1)) == other_cnt);
    st.shift_done  = !rv_r && (idx_r >= other_cnt);
    st.out_free    = !out_valid_r || out_tready;
  end

endmodule

`default_nettype wire

>>> design/exact_stamp_pair_synchronizer.sv
// Exact stamp pair synchronizer: pairs image and calibration items whose
// stamps are equal on all 62 bits, and forwards depth items.
//
// Channels: in_* is the item stream (in_tuser = mode), out_* the result
// stream (out_tuser = result kind), cfg_* a write port for the four
// registers; cfg_ready is always high.
// One item is worked at a time; in_tready is high only between items.
// Steps per item: a clear item empties both queues; an item of the wrong size
// is dropped; a depth item is forwarded when depth results are enabled, else
// dropped; an image or info item evicts the oldest entry of its own queue when
// that queue is full and scans the other queue for an equal stamp; on a match
// it closes the gap, one entry a cycle, and loads a pair result when pairs are
// enabled; with no equal stamp, or when the other queue is empty, it appends
// itself to its own queue.
// A result sits in the output register; when the receiver stalls the block
// still takes and works the next item and only waits once it has a second
// result to load. Reset empties both queues and the output register and
// loads the register reset values; queue memory contents are not cleared.
// Depends on esps_pkg, esps_ctrl and esps_datapath.
`default_nettype none

module exact_stamp_pair_synchronizer #(
  parameter int QUEUE_DEPTH = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tdata: stamp_sec[31:0], stamp_nanosec[61:32], frame_width[77:62],
  //        frame_height[93:78], item_tag[109:94], zero fill[111:110]
  input  wire logic [esps_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: mode[1:0]
  input  wire logic [esps_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: image_tag[15:0], info_tag[31:16], out_stamp_sec[63:32],
  //        out_stamp_nanosec[93:64], zero fill[95:94]
  output logic [esps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tuser: result_kind[0]
  output logic [0:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [esps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esps_pkg::*;

  cmd_t    cmd;
  status_t st;

  esps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  esps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // An accepted item blocks the input for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // A stamp hit during the scan is followed by closing the gap
  a_hit_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan && st.hit |=> cmd.shift)
    else $error("scan hit not followed by gap closing");

  // A result is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire
